### sv/lane_cell_occupancy_accumulator_defines.svh
// Assertion macros for the lane cell occupancy accumulator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef LANE_CELL_OCCUPANCY_ACCUMULATOR_DEFINES_SVH
`define LANE_CELL_OCCUPANCY_ACCUMULATOR_DEFINES_SVH

// condition holds at every edge out of reset
`define LCOA_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define LCOA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define LCOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/lcoa_pkg.sv
// Shared types, constants and helpers of the lane cell occupancy accumulator.
// No dependencies; imported by the report stage and the top level.
package lcoa_pkg;

	// table geometry
	localparam int MAX_LANES  = 4;
	localparam int MAX_CELLS  = 16;
	localparam int COUNT_BITS = 16;
	localparam int TABLE_SIZE = MAX_LANES * MAX_CELLS;
	localparam int ADDR_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int PTR_W      = $clog2(TABLE_SIZE + 1);
	localparam int LANE_W     = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
	localparam int CELL_W     = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int SNAP_W     = PTR_W;

	// field widths
	localparam int TOTAL_W   = 22;
	localparam int LEN_W     = 10;
	localparam int OCC_W     = 16;
	localparam int OFF_W     = 14;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = $clog2(MAX_CELLS + 1) + LEN_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_MODE = 2'd0,
		REG_LANES    = 2'd1,
		REG_CELLS    = 2'd2,
		REG_CELL_LEN = 2'd3
	} cfg_reg_t;

	// item kinds
	typedef enum logic {
		KIND_SAMPLE = 1'b0,
		KIND_DUMP   = 1'b1
	} kind_t;

	typedef struct packed {
		logic       kind;
		logic [1:0] lane;
		logic [3:0] cell_req;
		logic       occupied;
		logic       last_sample;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       lane_number;
		logic [OFF_W-1:0] offset;
		logic [OCC_W-1:0] occupancy;
		logic             last_result;
	} out_item_t;

	// scan stage to report stage
	typedef struct packed {
		logic                  found;
		logic                  flush;
		logic [LANE_W-1:0]     lane;
		logic [CELL_W-1:0]     cell_idx;
		logic [COUNT_BITS-1:0] count;
	} rpt_ctl_t;

	function automatic logic [OCC_W-1:0] sat_occ(input logic [COUNT_BITS-1:0] c);
		logic [32:0] w;
		w = 33'(c);
		return (w > 33'({OCC_W{1'b1}})) ? {OCC_W{1'b1}} : w[OCC_W-1:0];
	endfunction

	function automatic logic [OFF_W-1:0] sat_offset(input logic [PROD_W-1:0] p);
		logic [PROD_W+OFF_W-1:0] w;
		w = (PROD_W + OFF_W)'(p);
		return (w > (PROD_W + OFF_W)'({OFF_W{1'b1}})) ? {OFF_W{1'b1}} : w[OFF_W-1:0];
	endfunction

endpackage

### sv/lcoa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lcoa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### sv/lcoa_report.sv
// Dump report stage: holds one found cell back so the final one can be flagged.
// Depends on lcoa_pkg.
module lcoa_report
	import lcoa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  rpt_ctl_t         ctl,
	input  logic [LEN_W-1:0] cell_length,
	output logic             draining,
	output logic             strobe,
	output out_item_t        result
);

	logic             pend_vld_q;
	logic             fin_q;
	logic             strobe_q;
	out_item_t        pend_q;
	out_item_t        result_q;
	logic [PROD_W-1:0] prod;
	logic             emit_mid;
	logic             emit_fin;

	// cell end offset, (cell+1) * cell_length
	always_comb begin
		prod = (PROD_W'({1'b0, ctl.cell_idx}) + PROD_W'(1)) * PROD_W'(cell_length);
	end

	assign emit_mid = ctl.found && pend_vld_q;
	assign emit_fin = fin_q && pend_vld_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
			fin_q      <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= emit_mid || emit_fin;
			fin_q    <= ctl.flush;
			if (ctl.found) begin
				pend_vld_q <= 1'b1;
			end else if (fin_q) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.found) begin
			pend_q.lane_number <= 3'(ctl.lane) + 3'd1;
			pend_q.offset      <= sat_offset(prod);
			pend_q.occupancy   <= sat_occ(ctl.count);
			pend_q.last_result <= 1'b0;
		end
		if (emit_mid || emit_fin) begin
			result_q <= '{
				lane_number: pend_q.lane_number,
				offset:      pend_q.offset,
				occupancy:   pend_q.occupancy,
				last_result: emit_fin
			};
		end
	end

	assign draining = fin_q;
	assign strobe   = strobe_q;
	assign result   = result_q;

endmodule

### sv/lane_cell_occupancy_accumulator.sv
// Top level of the lane cell occupancy accumulator: control, config, memories.
// Depends on lcoa_pkg, lcoa_ram, lcoa_report and the assertion macro header.
//
//  channel   dir  handshake           payload
//  -------   ---  ------------------  ----------
//  item      in   start && !busy      in_item_t
//  result    out  strobe (1 cycle)    out_item_t
//  config    in   cfg_we              cfg_idx, cfg_data
//
// A cell sample does one memory read, then one write back.
// A max-mode commit adds a copy of the snapshot memory into the count memory.
// A dump of a nonzero table scans the count memory; results trail via the report stage.
// Reset clears entry valid flags at once; no clearing pass follows reset.
// Results cannot be held off; busy covers every cycle in which an item would collide.

`include "lane_cell_occupancy_accumulator_defines.svh"

module lane_cell_occupancy_accumulator
	import lcoa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_item_t             item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 strobe,
	output out_item_t            result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RMW,
		ST_COPY,
		ST_DUMP
	} state_t;

	state_t state_q;

	// configuration
	logic             max_mode_q;
	logic [2:0]       lanes_q;
	logic [4:0]       cells_q;
	logic [LEN_W-1:0] cell_len_q;

	// sample in flight
	in_item_t          samp_q;
	logic [ADDR_W-1:0] samp_addr_q;
	logic              samp_in_q;

	// totals and entry valid flags
	logic [TOTAL_W-1:0]    total_q;
	logic [SNAP_W-1:0]     snap_total_q;
	logic [TABLE_SIZE-1:0] cnt_vld_q;
	logic [TABLE_SIZE-1:0] snap_vld_q;

	// copy sweep
	logic [PTR_W-1:0]  ptr_q;
	logic              cp_vld_s1;
	logic [ADDR_W-1:0] cp_addr_s1;

	// dump scan
	logic [LANE_W-1:0] dl_q;
	logic [CELL_W-1:0] dc_q;
	logic              dscan_q;
	logic              dv_s1;
	logic              dlast_s1;
	logic [LANE_W-1:0] dl_s1;
	logic [CELL_W-1:0] dc_s1;
	logic [ADDR_W-1:0] da_s1;

	// memory ports
	logic                  cnt_we;
	logic [ADDR_W-1:0]     cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [ADDR_W-1:0]     cnt_raddr;
	logic [COUNT_BITS-1:0] cnt_rdata;
	logic                  snap_we;
	logic [ADDR_W-1:0]     snap_raddr;
	logic                  snap_rdata;

	logic                  accept;
	logic [ADDR_W-1:0]     item_addr;
	logic                  item_in;
	logic [ADDR_W-1:0]     dump_addr;
	logic                  issuing;
	logic [ADDR_W-1:0]     vld_addr;
	logic [COUNT_BITS-1:0] cnt_old;
	logic                  snap_old;
	logic [SNAP_W-1:0]     snap_total_nxt;
	logic                  commit;
	logic                  dump_in;
	logic                  rpt_draining;
	rpt_ctl_t              rpt_ctl;

	assign busy   = (state_q != ST_IDLE) || rpt_draining;
	assign accept = start && !busy;

	// item address and segment check
	assign item_addr = ADDR_W'(item.lane) * ADDR_W'(MAX_CELLS) + ADDR_W'(item.cell_req);
	assign item_in   = (3'(item.lane) < lanes_q) && (5'(item.lane) < 5'(MAX_LANES)) &&
		(5'(item.cell_req) < cells_q) && (9'(item.cell_req) < 9'(MAX_CELLS));

	assign dump_addr = ADDR_W'(dl_q) * ADDR_W'(MAX_CELLS) + ADDR_W'(dc_q);
	assign issuing   = ptr_q < PTR_W'(TABLE_SIZE);

	// read data masked by entry valid flags
	assign vld_addr = (state_q == ST_DUMP) ? da_s1 : samp_addr_q;
	assign cnt_old  = cnt_vld_q[vld_addr] ? cnt_rdata : '0;
	assign snap_old = snap_vld_q[samp_addr_q] & snap_rdata;

	// snapshot total after this sample, and the max-mode commit decision
	always_comb begin
		snap_total_nxt = snap_total_q;
		if (samp_in_q && max_mode_q) begin
			if (snap_old && !samp_q.occupied) begin
				snap_total_nxt = snap_total_q - SNAP_W'(1);
			end else if (!snap_old && samp_q.occupied) begin
				snap_total_nxt = snap_total_q + SNAP_W'(1);
			end
		end
	end
	assign commit = samp_q.last_sample && max_mode_q && (TOTAL_W'(snap_total_nxt) > total_q);

	// count memory ports
	always_comb begin
		cnt_we    = ((state_q == ST_RMW) && samp_in_q && !max_mode_q && samp_q.occupied) ||
			cp_vld_s1;
		cnt_waddr = cp_vld_s1 ? cp_addr_s1 : samp_addr_q;
		if (cp_vld_s1) begin
			cnt_wdata = COUNT_BITS'(snap_vld_q[cp_addr_s1] & snap_rdata);
		end else if (cnt_old == COUNT_MAX) begin
			cnt_wdata = cnt_old;
		end else begin
			cnt_wdata = cnt_old + COUNT_BITS'(1);
		end
		cnt_raddr = (state_q == ST_DUMP) ? dump_addr : item_addr;
	end

	// snapshot memory ports
	assign snap_we    = (state_q == ST_RMW) && samp_in_q && max_mode_q;
	assign snap_raddr = (state_q == ST_COPY) ? ptr_q[ADDR_W-1:0] : item_addr;

	lcoa_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(TABLE_SIZE)
	) u_cnt_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	lcoa_ram #(
		.WIDTH(1),
		.DEPTH(TABLE_SIZE)
	) u_snap_ram (
		.clk  (clk),
		.we   (snap_we),
		.waddr(samp_addr_q),
		.wdata(samp_q.occupied),
		.raddr(snap_raddr),
		.rdata(snap_rdata)
	);

	// dump scan results to the report stage
	assign dump_in = (5'(dl_s1) < 5'(lanes_q)) && (9'(dc_s1) < 9'(cells_q));
	always_comb begin
		rpt_ctl.found    = (state_q == ST_DUMP) && dv_s1 && dump_in && (cnt_old != '0);
		rpt_ctl.flush    = (state_q == ST_DUMP) && dv_s1 && dlast_s1;
		rpt_ctl.lane     = dl_s1;
		rpt_ctl.cell_idx = dc_s1;
		rpt_ctl.count    = cnt_old;
	end

	lcoa_report u_report (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (rpt_ctl),
		.cell_length(cell_len_q),
		.draining   (rpt_draining),
		.strobe     (strobe),
		.result     (result)
	);

	// control state machine and config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			max_mode_q   <= 1'b0;
			lanes_q      <= 3'd4;
			cells_q      <= 5'd16;
			cell_len_q   <= LEN_W'(75);
			samp_q       <= '0;
			samp_addr_q  <= '0;
			samp_in_q    <= 1'b0;
			total_q      <= '0;
			snap_total_q <= '0;
			cnt_vld_q    <= '0;
			snap_vld_q   <= '0;
			ptr_q        <= '0;
			cp_vld_s1    <= 1'b0;
			cp_addr_s1   <= '0;
			dl_q         <= '0;
			dc_q         <= '0;
			dscan_q      <= 1'b0;
			dv_s1        <= 1'b0;
			dlast_s1     <= 1'b0;
			dl_s1        <= '0;
			dc_s1        <= '0;
			da_s1        <= '0;
		end else begin
			// config writes
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_idx))
					REG_MAX_MODE: max_mode_q <= cfg_data[0];
					REG_LANES:    lanes_q    <= cfg_data[2:0];
					REG_CELLS:    cells_q    <= cfg_data[4:0];
					REG_CELL_LEN: cell_len_q <= cfg_data[LEN_W-1:0];
					default:      ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.kind == KIND_DUMP) begin
							if (total_q == '0) begin
								cnt_vld_q <= '0;
							end else begin
								dl_q    <= '0;
								dc_q    <= '0;
								dscan_q <= 1'b1;
								dv_s1   <= 1'b0;
								state_q <= ST_DUMP;
							end
						end else begin
							samp_q      <= item;
							samp_addr_q <= item_addr;
							samp_in_q   <= item_in;
							state_q     <= ST_RMW;
						end
					end
				end

				// write back the sample, close the step on its last sample
				ST_RMW: begin
					if (samp_in_q && !max_mode_q && samp_q.occupied) begin
						cnt_vld_q[samp_addr_q] <= 1'b1;
						if (total_q != TOTAL_MAX) begin
							total_q <= total_q + TOTAL_W'(1);
						end
					end
					if (samp_q.last_sample && !commit) begin
						snap_vld_q   <= '0;
						snap_total_q <= '0;
						state_q      <= ST_IDLE;
					end else begin
						if (samp_in_q && max_mode_q) begin
							snap_vld_q[samp_addr_q] <= 1'b1;
							snap_total_q            <= snap_total_nxt;
						end
						if (commit) begin
							total_q   <= TOTAL_W'(snap_total_nxt);
							ptr_q     <= '0;
							cp_vld_s1 <= 1'b0;
							state_q   <= ST_COPY;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end

				// snapshot replaces the table, one entry a cycle
				ST_COPY: begin
					cp_vld_s1  <= issuing;
					cp_addr_s1 <= ptr_q[ADDR_W-1:0];
					if (issuing) begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
					if (cp_vld_s1) begin
						cnt_vld_q[cp_addr_s1] <= 1'b1;
					end
					if (!issuing && !cp_vld_s1) begin
						snap_vld_q   <= '0;
						snap_total_q <= '0;
						state_q      <= ST_IDLE;
					end
				end

				// scan every entry in lane-major order, clear at the end
				ST_DUMP: begin
					dv_s1    <= dscan_q;
					dl_s1    <= dl_q;
					dc_s1    <= dc_q;
					da_s1    <= dump_addr;
					dlast_s1 <= dscan_q && (dl_q == LANE_W'(MAX_LANES - 1)) &&
						(dc_q == CELL_W'(MAX_CELLS - 1));
					if (dscan_q) begin
						if (dc_q == CELL_W'(MAX_CELLS - 1)) begin
							dc_q <= '0;
							if (dl_q == LANE_W'(MAX_LANES - 1)) begin
								dscan_q <= 1'b0;
							end else begin
								dl_q <= dl_q + LANE_W'(1);
							end
						end else begin
							dc_q <= dc_q + CELL_W'(1);
						end
					end
					// scan already stopped, so dv_s1 falls on its own
					if (dv_s1 && dlast_s1) begin
						cnt_vld_q <= '0;
						total_q   <= '0;
						state_q   <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// checks
	`LCOA_ASSERT_ALWAYS(a_snap_total_range, snap_total_q <= SNAP_W'(TABLE_SIZE), "snapshot total beyond table size")
	`LCOA_ASSERT_NEXT(a_sample_busy, accept && (item.kind == KIND_SAMPLE), busy, "sample transfer did not raise busy")
	`LCOA_ASSERT_SAME(a_result_after_busy, strobe, $past(busy), "result transfer outside a dump")
	`LCOA_ASSERT_SAME(a_copy_max_mode, state_q == ST_COPY, max_mode_q, "snapshot copy in accumulate mode")

endmodule
